// ----- rtl/ubfc_pkg.sv -----
package ubfc_pkg;

    localparam int DEF_TX_DEPTH = 256;
    localparam int DEF_RX_DEPTH = 256;
    localparam int BYTE_W       = 8;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_IRQ   = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        logic accepted;
        logic line_tx_valid;
        logic rx_notify;
        logic tx_done;
        logic txe_irq_on;
        logic tc_irq_on;
        logic tx_idle;
        logic rx_overflow;
    } t_flags;

endpackage

// ----- rtl/ubfc_ram.sv -----
module ubfc_ram
    import ubfc_pkg::*;
#(
    parameter int DEPTH = DEF_TX_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_q;
    logic [BYTE_W-1:0] r_fwd;
    logic              r_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q   <= r_mem[i_raddr];
        r_fwd <= i_wdata;
        r_hit <= i_we && (i_waddr == i_raddr);
    end

    assign o_rdata = r_hit ? r_fwd : r_q;

endmodule

// ----- rtl/ubfc_ctrl.sv -----
module ubfc_ctrl
    import ubfc_pkg::*;
#(
    parameter int TX_DEPTH = DEF_TX_DEPTH,
    parameter int RX_DEPTH = DEF_RX_DEPTH,
    parameter int TX_AW    = $clog2(TX_DEPTH),
    parameter int RX_AW    = $clog2(RX_DEPTH),
    parameter int TX_FW    = $clog2(TX_DEPTH + 1),
    parameter int RX_FW    = $clog2(RX_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  t_kind             i_kind,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_last,
    input  logic              i_rxr,
    input  logic              i_txe,
    input  logic              i_tc,
    input  logic [BYTE_W-1:0] i_tx_rd,
    input  logic [BYTE_W-1:0] i_rx_rd,
    output logic              o_tx_we,
    output logic [TX_AW-1:0]  o_tx_waddr,
    output logic [TX_AW-1:0]  o_tx_raddr,
    output logic              o_rx_we,
    output logic [RX_AW-1:0]  o_rx_waddr,
    output logic [RX_AW-1:0]  o_rx_raddr,
    output t_flags            o_flags,
    output logic [BYTE_W-1:0] o_read_data,
    output logic [BYTE_W-1:0] o_line_tx_data,
    output logic [RX_FW-1:0]  o_rx_level,
    output logic [TX_FW-1:0]  o_tx_level
);

    logic [TX_AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [TX_FW-1:0] r_tx_fill, n_tx_fill;
    logic [RX_AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [RX_FW-1:0] r_rx_fill, n_rx_fill;
    logic             r_busy, n_busy, r_txe_en, n_txe_en, r_tc_en, n_tc_en;
    t_flags           flags;

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_tx_head      = r_tx_head;
        n_tx_tail      = r_tx_tail;
        n_tx_fill      = r_tx_fill;
        n_rx_head      = r_rx_head;
        n_rx_tail      = r_rx_tail;
        n_rx_fill      = r_rx_fill;
        n_busy         = r_busy;
        n_txe_en       = r_txe_en;
        n_tc_en        = r_tc_en;
        flags          = '0;
        o_read_data    = '0;
        o_line_tx_data = '0;
        o_tx_we        = 1'b0;
        o_rx_we        = 1'b0;
        if (i_go) begin
            case (i_kind)
                KIND_PUSH: begin
                    if (r_tx_fill != TX_FW'(TX_DEPTH)) begin
                        o_tx_we        = 1'b1;
                        n_tx_head      = tx_next(r_tx_head);
                        n_tx_fill      = r_tx_fill + 1'b1;
                        flags.accepted = 1'b1;
                        if (i_last) begin
                            n_txe_en = 1'b1;
                        end
                    end else begin
                        n_txe_en = 1'b1;
                    end
                end
                KIND_POP: begin
                    if (r_rx_fill != '0) begin
                        o_read_data    = i_rx_rd;
                        n_rx_tail      = rx_next(r_rx_tail);
                        n_rx_fill      = r_rx_fill - 1'b1;
                        flags.accepted = 1'b1;
                    end
                end
                KIND_IRQ: begin
                    if (i_rxr) begin
                        o_rx_we   = 1'b1;
                        n_rx_head = rx_next(r_rx_head);
                        if (r_rx_fill != RX_FW'(RX_DEPTH)) begin
                            n_rx_fill = r_rx_fill + 1'b1;
                        end else begin
                            n_rx_tail         = rx_next(r_rx_tail);
                            flags.rx_overflow = 1'b1;
                        end
                        flags.rx_notify = 1'b1;
                    end
                    if (i_txe && r_txe_en) begin
                        if (r_tx_fill == '0) begin
                            n_txe_en = 1'b0;
                            n_tc_en  = 1'b1;
                        end else begin
                            n_busy              = 1'b1;
                            o_line_tx_data      = i_tx_rd;
                            flags.line_tx_valid = 1'b1;
                            n_tx_tail           = tx_next(r_tx_tail);
                            n_tx_fill           = r_tx_fill - 1'b1;
                        end
                    end
                    if (i_tc && r_tc_en) begin
                        if (n_tx_fill == '0) begin
                            n_tc_en       = 1'b0;
                            n_busy        = 1'b0;
                            flags.tx_done = 1'b1;
                        end else if (!flags.line_tx_valid) begin
                            o_line_tx_data      = i_tx_rd;
                            flags.line_tx_valid = 1'b1;
                            n_tx_tail           = tx_next(r_tx_tail);
                            n_tx_fill           = r_tx_fill - 1'b1;
                        end
                    end
                end
                KIND_CLEAR: begin
                    n_tx_head = '0;
                    n_tx_tail = '0;
                    n_tx_fill = '0;
                end
                default: begin
                    n_tx_fill = r_tx_fill;
                end
            endcase
        end
        flags.txe_irq_on = n_txe_en;
        flags.tc_irq_on  = n_tc_en;
        flags.tx_idle    = !n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_fill <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_rx_fill <= '0;
            r_busy    <= 1'b0;
            r_txe_en  <= 1'b0;
            r_tc_en   <= 1'b0;
        end else begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_tx_fill <= n_tx_fill;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_rx_fill <= n_rx_fill;
            r_busy    <= n_busy;
            r_txe_en  <= n_txe_en;
            r_tc_en   <= n_tc_en;
        end
    end

    assign o_tx_waddr = r_tx_head;
    assign o_tx_raddr = n_tx_tail;
    assign o_rx_waddr = r_rx_head;
    assign o_rx_raddr = n_rx_tail;
    assign o_flags    = flags;
    assign o_rx_level = n_rx_fill;
    assign o_tx_level = n_tx_fill;

endmodule

// ----- rtl/uart_buffered_fifo_controller_core.sv -----
// channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_kind i_data i_last_in_burst i_rx_ready
//         |            |             | i_tx_reg_empty i_tx_complete
// out     | o_out_valid| i_out_ready | o_accepted o_read_data o_line_tx_* o_rx_notify
//         |            |             | o_tx_done o_*_irq_on o_tx_idle o_rx_overflow o_*_level
// One item per cycle unless a held result stalls; input register, then result register.
// Ring reads use a prefetch of the tail entry, so one memory read port per ring suffices.
// Reset (i_rst_n low, synchronous) clears pointers, fill counts, enables and sending flag;
// ring contents are not cleared.
// A held result stalls processing; the input stage still takes one item while it is empty.
module uart_buffered_fifo_controller_core
    import ubfc_pkg::*;
#(
    parameter int TX_DEPTH = DEF_TX_DEPTH,
    parameter int RX_DEPTH = DEF_RX_DEPTH,
    parameter int TX_AW    = $clog2(TX_DEPTH),
    parameter int RX_AW    = $clog2(RX_DEPTH),
    parameter int TX_FW    = $clog2(TX_DEPTH + 1),
    parameter int RX_FW    = $clog2(RX_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_last_in_burst,
    input  logic              i_rx_ready,
    input  logic              i_tx_reg_empty,
    input  logic              i_tx_complete,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_accepted,
    output logic [BYTE_W-1:0] o_read_data,
    output logic              o_line_tx_valid,
    output logic [BYTE_W-1:0] o_line_tx_data,
    output logic              o_rx_notify,
    output logic              o_tx_done,
    output logic              o_txe_irq_on,
    output logic              o_tc_irq_on,
    output logic              o_tx_idle,
    output logic              o_rx_overflow,
    output logic [RX_FW-1:0]  o_rx_level,
    output logic [TX_FW-1:0]  o_tx_level
);

    logic              r_in_valid;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_data;
    logic              r_last, r_rxr, r_txe, r_tc;

    logic              r_out_valid;
    t_flags            r_flags;
    logic [BYTE_W-1:0] r_read_data, r_line_tx_data;
    logic [RX_FW-1:0]  r_rx_level;
    logic [TX_FW-1:0]  r_tx_level;

    logic              stall, go;
    logic              tx_we, rx_we;
    logic [TX_AW-1:0]  tx_waddr, tx_raddr;
    logic [RX_AW-1:0]  rx_waddr, rx_raddr;
    logic [BYTE_W-1:0] tx_rd, rx_rd, read_data, line_tx_data;
    t_flags            flags;
    logic [RX_FW-1:0]  rx_level;
    logic [TX_FW-1:0]  tx_level;

    assign stall      = r_out_valid && !i_out_ready;
    assign go         = r_in_valid && !stall;
    assign o_in_ready = !r_in_valid || !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_kind <= t_kind'(i_kind);
            r_data <= i_data;
            r_last <= i_last_in_burst;
            r_rxr  <= i_rx_ready;
            r_txe  <= i_tx_reg_empty;
            r_tc   <= i_tx_complete;
        end
        if (go) begin
            r_flags        <= flags;
            r_read_data    <= read_data;
            r_line_tx_data <= line_tx_data;
            r_rx_level     <= rx_level;
            r_tx_level     <= tx_level;
        end
    end

    ubfc_ctrl #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH),
        .TX_AW    (TX_AW),
        .RX_AW    (RX_AW),
        .TX_FW    (TX_FW),
        .RX_FW    (RX_FW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_kind         (r_kind),
        .i_data         (r_data),
        .i_last         (r_last),
        .i_rxr          (r_rxr),
        .i_txe          (r_txe),
        .i_tc           (r_tc),
        .i_tx_rd        (tx_rd),
        .i_rx_rd        (rx_rd),
        .o_tx_we        (tx_we),
        .o_tx_waddr     (tx_waddr),
        .o_tx_raddr     (tx_raddr),
        .o_rx_we        (rx_we),
        .o_rx_waddr     (rx_waddr),
        .o_rx_raddr     (rx_raddr),
        .o_flags        (flags),
        .o_read_data    (read_data),
        .o_line_tx_data (line_tx_data),
        .o_rx_level     (rx_level),
        .o_tx_level     (tx_level)
    );

    ubfc_ram #(
        .DEPTH (TX_DEPTH),
        .AW    (TX_AW)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (r_data),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rd)
    );

    ubfc_ram #(
        .DEPTH (RX_DEPTH),
        .AW    (RX_AW)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (r_data),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rd)
    );

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_flags.accepted;
    assign o_read_data     = r_read_data;
    assign o_line_tx_valid = r_flags.line_tx_valid;
    assign o_line_tx_data  = r_line_tx_data;
    assign o_rx_notify     = r_flags.rx_notify;
    assign o_tx_done       = r_flags.tx_done;
    assign o_txe_irq_on    = r_flags.txe_irq_on;
    assign o_tc_irq_on     = r_flags.tc_irq_on;
    assign o_tx_idle       = r_flags.tx_idle;
    assign o_rx_overflow   = r_flags.rx_overflow;
    assign o_rx_level      = r_rx_level;
    assign o_tx_level      = r_tx_level;

`ifndef SYNTHESIS
    a_tx_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tx_level <= TX_FW'(TX_DEPTH)))
        else $error("tx level above ring depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rx_overflow) |-> (o_rx_notify && o_rx_level == RX_FW'(RX_DEPTH)))
        else $error("overflow without full receive ring");

    a_done_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_done) |-> (o_tx_idle && o_tx_level == '0))
        else $error("tx done while bytes remain");

    a_go_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> o_out_valid)
        else $error("processed item produced no result");
`endif

endmodule

// ----- verif/uart_buffered_fifo_controller_core_test.sv -----
module uart_buffered_fifo_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ubfc_pkg::*;

    localparam int TX_SLOTS       = DEF_TX_DEPTH;
    localparam int RX_SLOTS       = DEF_RX_DEPTH;
    localparam int LVL_W          = $clog2(DEF_TX_DEPTH + 1);
    localparam int RANDOM_ITEMS   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam int LONG_HOLD_AT   = 200;
    localparam int CALM_TAIL      = 80;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic        rxr;
        logic        txe;
        logic        tc;
    } t_uart_req;

    typedef struct packed {
        t_flags           flags;
        logic [7:0]       read_data;
        logic [7:0]       line_data;
        logic [LVL_W-1:0] rx_level;
        logic [LVL_W-1:0] tx_level;
    } t_uart_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_kind = KIND_PUSH;
    logic [BYTE_W-1:0] i_data = '0;
    logic              i_last_in_burst = 1'b0;
    logic              i_rx_ready = 1'b0;
    logic              i_tx_reg_empty = 1'b0;
    logic              i_tx_complete = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_accepted;
    logic [BYTE_W-1:0] o_read_data;
    logic              o_line_tx_valid;
    logic [BYTE_W-1:0] o_line_tx_data;
    logic              o_rx_notify;
    logic              o_tx_done;
    logic              o_txe_irq_on;
    logic              o_tc_irq_on;
    logic              o_tx_idle;
    logic              o_rx_overflow;
    logic [LVL_W-1:0]  o_rx_level;
    logic [LVL_W-1:0]  o_tx_level;

    uart_buffered_fifo_controller_core dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_uart_req    pending_items[$];
    t_uart_status ring_results_due[$];

    logic [7:0]  tx_ring [TX_SLOTS];
    logic [7:0]  rx_ring [RX_SLOTS];
    int unsigned tx_wr = 0, tx_rd = 0, tx_count = 0;
    int unsigned rx_wr = 0, rx_rd = 0, rx_count = 0;
    bit          sending = 0, txe_en = 0, tc_en = 0;

    int  total_items = 0;
    int  items_taken = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  covered_refusals = 0, covered_overflows = 0, covered_done = 0, covered_sends = 0;
    bit  in_taken = 0;
    int  send_gap = 0;
    int  hold_left = 0;
    bit  long_hold_done = 0;

    function automatic logic [7:0] take_tx_byte();
        logic [7:0] b;
        b = tx_ring[tx_rd];
        tx_rd = (tx_rd + 1) % TX_SLOTS;
        tx_count--;
        return b;
    endfunction

    task automatic ring_step(input t_uart_req r, output t_uart_status s);
        bit txe_was, tc_was;
        s = '0;
        txe_was = txe_en;
        tc_was = tc_en;
        case (r.kind)
            KIND_PUSH: begin
                if (tx_count < TX_SLOTS) begin
                    tx_ring[tx_wr] = r.data;
                    tx_wr = (tx_wr + 1) % TX_SLOTS;
                    tx_count++;
                    s.flags.accepted = 1'b1;
                    if (r.last)
                        txe_en = 1;
                end else begin
                    txe_en = 1;
                end
            end
            KIND_POP: begin
                if (rx_count != 0) begin
                    s.read_data = rx_ring[rx_rd];
                    rx_rd = (rx_rd + 1) % RX_SLOTS;
                    rx_count--;
                    s.flags.accepted = 1'b1;
                end
            end
            KIND_IRQ: begin
                if (r.rxr) begin
                    rx_ring[rx_wr] = r.data;
                    rx_wr = (rx_wr + 1) % RX_SLOTS;
                    if (rx_count < RX_SLOTS) begin
                        rx_count++;
                    end else begin
                        rx_rd = (rx_rd + 1) % RX_SLOTS;
                        s.flags.rx_overflow = 1'b1;
                    end
                    s.flags.rx_notify = 1'b1;
                end
                if (r.txe && txe_was) begin
                    if (tx_count == 0) begin
                        txe_en = 0;
                        tc_en = 1;
                    end else begin
                        sending = 1;
                        s.line_data = take_tx_byte();
                        s.flags.line_tx_valid = 1'b1;
                    end
                end
                if (r.tc && tc_was) begin
                    if (tx_count == 0) begin
                        tc_en = 0;
                        sending = 0;
                        s.flags.tx_done = 1'b1;
                    end else if (!s.flags.line_tx_valid) begin
                        s.line_data = take_tx_byte();
                        s.flags.line_tx_valid = 1'b1;
                    end
                end
            end
            default: begin
                tx_wr = 0;
                tx_rd = 0;
                tx_count = 0;
            end
        endcase
        s.flags.txe_irq_on = txe_en;
        s.flags.tc_irq_on = tc_en;
        s.flags.tx_idle = !sending;
        s.rx_level = LVL_W'(rx_count);
        s.tx_level = LVL_W'(tx_count);
    endtask

    task automatic check_field(input string name, input int unsigned want, got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected 0x%0h, actual 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    task automatic add_item(input t_kind k, input logic [7:0] d,
                            input logic last, rxr, txe, tc);
        t_uart_req r;
        r.kind = k;
        r.data = d;
        r.last = last;
        r.rxr = rxr;
        r.txe = txe;
        r.tc = tc;
        pending_items.push_back(r);
    endtask

    // predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_uart_req    req;
        t_uart_status want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                req.kind = t_kind'(i_kind);
                req.data = i_data;
                req.last = i_last_in_burst;
                req.rxr = i_rx_ready;
                req.txe = i_tx_reg_empty;
                req.tc = i_tx_complete;
                ring_step(req, want);
                ring_results_due.push_back(want);
                items_taken++;
                if (req.kind == KIND_PUSH && !want.flags.accepted)
                    covered_refusals++;
                covered_overflows += want.flags.rx_overflow;
                covered_done += want.flags.tx_done;
                covered_sends += want.flags.line_tx_valid;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (ring_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result %0d: nothing pending", results_seen);
                end else begin
                    want = ring_results_due.pop_front();
                    check_field("accepted", want.flags.accepted, o_accepted);
                    check_field("read_data", want.read_data, o_read_data);
                    check_field("line_tx_valid", want.flags.line_tx_valid, o_line_tx_valid);
                    check_field("line_tx_data", want.line_data, o_line_tx_data);
                    check_field("rx_notify", want.flags.rx_notify, o_rx_notify);
                    check_field("tx_done", want.flags.tx_done, o_tx_done);
                    check_field("txe_irq_on", want.flags.txe_irq_on, o_txe_irq_on);
                    check_field("tc_irq_on", want.flags.tc_irq_on, o_tc_irq_on);
                    check_field("tx_idle", want.flags.tx_idle, o_tx_idle);
                    check_field("rx_overflow", want.flags.rx_overflow, o_rx_overflow);
                    check_field("rx_level", want.rx_level, o_rx_level);
                    check_field("tx_level", want.tx_level, o_tx_level);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    // sender: hold until transfer, then idle or advance
    always @(negedge i_clk) begin
        t_uart_req nxt;
        bit        offer;
        offer = 0;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() != 0) begin
                if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 11) - 1;
                end else begin
                    nxt = pending_items.pop_front();
                    offer = 1;
                end
            end
            i_in_valid <= offer;
            if (offer) begin
                i_kind <= nxt.kind;
                i_data <= nxt.data;
                i_last_in_burst <= nxt.last;
                i_rx_ready <= nxt.rxr;
                i_tx_reg_empty <= nxt.txe;
                i_tx_complete <= nxt.tc;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1;
            hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        int pick;
        t_kind k;

        add_item(KIND_POP,   8'hA5, 1, 1, 1, 1);
        add_item(KIND_IRQ,   8'h00, 0, 0, 1, 1);
        add_item(KIND_PUSH,  8'hFF, 0, 1, 1, 1);
        add_item(KIND_PUSH,  8'h00, 1, 0, 0, 0);
        add_item(KIND_IRQ,   8'h5A, 0, 1, 1, 0);
        add_item(KIND_IRQ,   8'hC3, 1, 0, 1, 0);
        add_item(KIND_IRQ,   8'h00, 0, 0, 1, 1);
        add_item(KIND_PUSH,  8'h81, 0, 0, 0, 0);
        add_item(KIND_IRQ,   8'h00, 0, 0, 0, 1);
        add_item(KIND_PUSH,  8'h7E, 1, 0, 0, 0);
        add_item(KIND_PUSH,  8'h33, 0, 0, 0, 0);
        add_item(KIND_IRQ,   8'h00, 0, 0, 1, 1);
        add_item(KIND_CLEAR, 8'hFF, 1, 1, 1, 1);
        add_item(KIND_IRQ,   8'hFF, 1, 1, 1, 1);
        add_item(KIND_IRQ,   8'h00, 0, 1, 0, 0);
        repeat (4) add_item(KIND_POP, 8'h00, 0, 0, 0, 0);

        // fill the transmit ring past full, send a few, then clear
        repeat (TX_SLOTS + 1)
            add_item(KIND_PUSH, 8'($urandom), 0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (2) add_item(KIND_IRQ, 8'($urandom), 0, 0, 1, 0);
        add_item(KIND_CLEAR, 8'($urandom), 0, 0, 0, 0);

        // overrun the receive ring
        repeat (RX_SLOTS + 1)
            add_item(KIND_IRQ, 8'($urandom), 1'($urandom_range(0, 1)), 1,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                k = KIND_PUSH;
            else if (pick < 55)
                k = KIND_POP;
            else if (pick < 95)
                k = KIND_IRQ;
            else
                k = KIND_CLEAR;
            add_item(k, 8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        total_items = pending_items.size();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(items_taken == total_items && ring_results_due.size() == 0)
               && quiet_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);

        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d of %0d items taken",
                     quiet_cycles, items_taken, total_items);
            $display("*** FAILED ***");
        end else begin
            repeat (10) @(negedge i_clk);
            $display("%0d items in, %0d results checked, %0d field mismatches",
                     items_taken, results_seen, mismatches);
            $display("%0d line bytes, %0d refused pushes, %0d rx overruns, %0d tx completions",
                     covered_sends, covered_refusals, covered_overflows, covered_done);
            if (mismatches == 0 && ring_results_due.size() == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
